FILE: sv/cat_pkg.sv
`timescale 1ns / 1ps

package cat_pkg;

    // Input actions
    localparam logic [2:0] ACT_CALL_REQ  = 3'd0;
    localparam logic [2:0] ACT_DROP_REQ  = 3'd1;
    localparam logic [2:0] ACT_ACCEPT    = 3'd2;
    localparam logic [2:0] ACT_REJECT    = 3'd3;
    localparam logic [2:0] ACT_ERROR     = 3'd4;
    localparam logic [2:0] ACT_DROP_DONE = 3'd5;
    localparam logic [2:0] ACT_LOST      = 3'd6;
    localparam logic [2:0] ACT_FAILED    = 3'd7;

    // Result status codes
    localparam logic [3:0] ST_ISSUED     = 4'd0;
    localparam logic [3:0] ST_QUEUED     = 4'd1;
    localparam logic [3:0] ST_DUP_REQ    = 4'd2;
    localparam logic [3:0] ST_DROP_TRK   = 4'd3;
    localparam logic [3:0] ST_DROP_UNTRK = 4'd4;
    localparam logic [3:0] ST_UPDATED    = 4'd5;
    localparam logic [3:0] ST_UNKNOWN    = 4'd6;
    localparam logic [3:0] ST_DUP_CALL   = 4'd7;
    localparam logic [3:0] ST_QFULL      = 4'd8;
    localparam logic [3:0] ST_TFULL      = 4'd9;

    // Scan index covers tables of up to 64 entries.
    localparam int SCAN_IW = 6;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [SCAN_IW-1:0] hit_idx;
        logic               free;
        logic [SCAN_IW-1:0] free_idx;
    } t_scan_res;

endpackage

FILE: sv/cat_scan.sv
`timescale 1ns / 1ps

// Shared lookup unit: walks one table entry per cycle with a single 32-bit
// comparator and reports the first matching entry and the first free entry.
// The table data arrives in the cycle after the address is presented.
module cat_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cat_pkg::SCAN_IW:0]   i_len,
    input  logic [31:0]                 i_key,
    input  logic [31:0]                 i_ent_id,
    input  logic                        i_ent_vld,
    output logic [cat_pkg::SCAN_IW-1:0] o_idx,
    output cat_pkg::t_scan_res          o_res
);

    logic                        r_run;
    logic [cat_pkg::SCAN_IW:0]   r_cnt;
    logic                        r_cmp;
    logic [cat_pkg::SCAN_IW-1:0] r_cmp_idx;
    logic                        r_done;
    logic                        r_hit;
    logic [cat_pkg::SCAN_IW-1:0] r_hit_idx;
    logic                        r_free;
    logic [cat_pkg::SCAN_IW-1:0] r_free_idx;
    logic                        w_last_addr;
    logic                        w_last_cmp;

    assign w_last_addr = (r_cnt == i_len - 1'b1);
    assign w_last_cmp  = ({1'b0, r_cmp_idx} == i_len - 1'b1);
    assign o_idx       = r_cnt[cat_pkg::SCAN_IW-1:0];

    // Address counter, compare stage and result capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cmp  <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_cmp  <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cmp     <= r_run;
            r_cmp_idx <= r_cnt[cat_pkg::SCAN_IW-1:0];
            if (r_run) begin
                if (w_last_addr) begin
                    r_run <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            r_done <= r_cmp && w_last_cmp;
            if (r_cmp) begin
                if (i_ent_vld && i_ent_id == i_key && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!i_ent_vld && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

    assign o_res = '{done: r_done, hit: r_hit, hit_idx: r_hit_idx,
                     free: r_free, free_idx: r_free_idx};

endmodule

FILE: sv/call_admission_tracker_unit.sv
`timescale 1ns / 1ps

// Call admission tracker.
// Input beats arrive on the s_axis channel: tuser carries the action, tdata
// the request id and call id. Result beats leave on m_axis: tuser carries the
// status, tdata the request id and call id, tlast marks the final result of
// an input beat. An input beat yields one result, plus one per queued request
// popped while draining after a removal.
// Every lookup walks the target table one entry per cycle through a single
// shared comparator. An input beat takes up to two lookups; a call request
// that meets the max_active limit takes none. Each drained request adds one
// more lookup. s_axis_tready is high only while the sequencer is idle. The
// limit max_active is written over the APB port at any address with paddr[2]
// low; the user must write it only while idle, the block does not enforce it.
// Reset clears the queue, all valid bits and sets max_active to 4. A stalled
// receiver holds the result register; the sequencer waits with the next
// result, and a new input beat is taken while the last result still waits.
module call_admission_tracker_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_DEPTH = 16,
    parameter int DROP_DEPTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] req_id, [63:32] call_id
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_req_id, [63:32] out_call_id
    output logic [3:0]  m_axis_tuser,   // [3:0] status
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int DW = (DROP_DEPTH > 1) ? $clog2(DROP_DEPTH) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int TCW = $clog2(TRACK_DEPTH + 1);
    localparam int AW0 = $clog2(2 * TRACK_DEPTH + 1);
    localparam int AW = (AW0 > 5) ? AW0 : 5;
    localparam int IW = cat_pkg::SCAN_IW;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DCALL = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;

    // Lookup steps
    localparam logic [3:0] P_ISSUE    = 4'd0;
    localparam logic [3:0] P_D1_LIVE  = 4'd1;
    localparam logic [3:0] P_D1_DROP  = 4'd2;
    localparam logic [3:0] P_ACC_OPEN = 4'd3;
    localparam logic [3:0] P_ACC_LIVE = 4'd4;
    localparam logic [3:0] P_REJ_OPEN = 4'd5;
    localparam logic [3:0] P_REJ_DROP = 4'd6;
    localparam logic [3:0] P_DD_DROP  = 4'd7;
    localparam logic [3:0] P_DD_LIVE  = 4'd8;
    localparam logic [3:0] P_LOST     = 4'd9;

    // Table selects
    localparam logic [1:0] T_OPEN = 2'd0;
    localparam logic [1:0] T_LIVE = 2'd1;
    localparam logic [1:0] T_DROP = 2'd2;

    localparam logic [IW:0] LEN_T = (IW + 1)'(TRACK_DEPTH);
    localparam logic [IW:0] LEN_D = (IW + 1)'(DROP_DEPTH);

    // Storage
    logic [31:0]            r_open_id [TRACK_DEPTH];
    logic [TRACK_DEPTH-1:0] r_open_v;
    logic [31:0]            r_live_id [TRACK_DEPTH];
    logic [TRACK_DEPTH-1:0] r_live_v;
    logic [31:0]            r_drop_id [DROP_DEPTH];
    logic [DROP_DEPTH-1:0]  r_drop_v;
    logic [31:0]            r_dcall   [DROP_DEPTH];
    logic [31:0]            r_fifo    [QUEUE_DEPTH];

    // Control registers
    logic [2:0]   r_state, n_state;
    logic [3:0]   r_step, n_step;
    logic [31:0]  r_key, n_key;
    logic [IW:0]  r_len, n_len;
    logic         r_start, n_start;
    logic [3:0]   r_st, n_st;
    logic [31:0]  r_oq, n_oq;
    logic [31:0]  r_oc, n_oc;
    logic         r_drain, n_drain;
    logic [4:0]   r_max;
    logic [QW-1:0]  r_head;
    logic [QCW-1:0] r_qcnt;
    logic [TCW-1:0] r_open_cnt;
    logic [TCW-1:0] r_live_cnt;
    logic [31:0]  r_rd;
    logic [31:0]  r_dc;
    logic [31:0]  r_ent_id;
    logic         r_ent_v;
    logic         r_m_vld;
    logic [3:0]   r_m_st;
    logic [31:0]  r_m_rq;
    logic [31:0]  r_m_cl;
    logic         r_m_last;

    // Strobes
    logic w_open_set, w_open_clr, w_live_set, w_live_clr;
    logic w_drop_set, w_drop_clr, w_push, w_pop, w_load;
    logic w_accept, w_act_lt, w_more;
    logic [1:0]    w_sel;
    logic [IW-1:0] w_idx;
    logic [QW:0]   w_tail_sum;
    logic [QW-1:0] w_tail;
    logic [AW-1:0] w_act;
    cat_pkg::t_scan_res w_res;

    cat_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_len     (r_len),
        .i_key     (r_key),
        .i_ent_id  (r_ent_id),
        .i_ent_vld (r_ent_v),
        .o_idx     (w_idx),
        .o_res     (w_res)
    );

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_act = AW'(r_open_cnt) + AW'(r_live_cnt);
    assign w_act_lt = (w_act < AW'(r_max));
    assign w_more = r_drain && w_act_lt && (r_qcnt != '0);
    assign w_load = (r_state == S_EMIT) && (!r_m_vld || m_axis_tready);
    assign w_tail_sum = (QW + 1)'(r_head) + (QW + 1)'(r_qcnt);
    assign w_tail = (w_tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                    QW'(w_tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(w_tail_sum);

    // Which table the current step reads.
    always_comb begin
        case (r_step)
            P_ISSUE, P_ACC_OPEN, P_REJ_OPEN: w_sel = T_OPEN;
            P_D1_DROP, P_REJ_DROP, P_DD_DROP: w_sel = T_DROP;
            default: w_sel = T_LIVE;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_key   = r_key;
        n_len   = r_len;
        n_start = 1'b0;
        n_st    = r_st;
        n_oq    = r_oq;
        n_oc    = r_oc;
        n_drain = r_drain;
        w_open_set = 1'b0;
        w_open_clr = 1'b0;
        w_live_set = 1'b0;
        w_live_clr = 1'b0;
        w_drop_set = 1'b0;
        w_drop_clr = 1'b0;
        w_push = 1'b0;
        w_pop  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_oq    = s_axis_tdata[31:0];
                    n_oc    = s_axis_tdata[63:32];
                    n_drain = 1'b0;
                    n_start = 1'b1;
                    n_state = S_SCAN;
                    n_len   = LEN_T;
                    n_key   = s_axis_tdata[31:0];
                    case (s_axis_tuser)
                        cat_pkg::ACT_CALL_REQ: begin
                            n_step = P_ISSUE;
                            if (!w_act_lt) begin
                                n_start = 1'b0;
                                n_state = S_EMIT;
                                if (r_qcnt < QCW'(QUEUE_DEPTH)) begin
                                    w_push = 1'b1;
                                    n_st   = cat_pkg::ST_QUEUED;
                                end else begin
                                    n_st = cat_pkg::ST_QFULL;
                                end
                            end
                        end
                        cat_pkg::ACT_DROP_REQ: begin
                            n_step = P_D1_LIVE;
                            n_key  = s_axis_tdata[63:32];
                        end
                        cat_pkg::ACT_ACCEPT: n_step = P_ACC_OPEN;
                        cat_pkg::ACT_REJECT, cat_pkg::ACT_ERROR: n_step = P_REJ_OPEN;
                        cat_pkg::ACT_DROP_DONE: begin
                            n_step = P_DD_DROP;
                            n_len  = LEN_D;
                        end
                        default: begin
                            n_step = P_LOST;
                            n_key  = s_axis_tdata[63:32];
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_res.done) begin
                    n_state = S_EMIT;
                    n_st    = cat_pkg::ST_UNKNOWN;
                    case (r_step)
                        P_ISSUE: begin
                            if (w_res.hit) begin
                                n_st = cat_pkg::ST_DUP_REQ;
                            end else if (w_res.free) begin
                                w_open_set = 1'b1;
                                n_st = cat_pkg::ST_ISSUED;
                            end else begin
                                n_st = cat_pkg::ST_TFULL;
                            end
                        end
                        P_D1_LIVE: begin
                            if (!w_res.hit) begin
                                n_st = cat_pkg::ST_DROP_UNTRK;
                            end else begin
                                n_state = S_SCAN;
                                n_start = 1'b1;
                                n_step  = P_D1_DROP;
                                n_key   = r_oq;
                                n_len   = LEN_D;
                            end
                        end
                        P_D1_DROP: begin
                            if (w_res.hit) begin
                                n_st = cat_pkg::ST_DROP_TRK;
                            end else if (w_res.free) begin
                                w_drop_set = 1'b1;
                                n_st = cat_pkg::ST_DROP_TRK;
                            end else begin
                                n_st = cat_pkg::ST_TFULL;
                            end
                        end
                        P_ACC_OPEN: begin
                            if (w_res.hit) begin
                                w_open_clr = 1'b1;
                                n_state = S_SCAN;
                                n_start = 1'b1;
                                n_step  = P_ACC_LIVE;
                                n_key   = r_oc;
                                n_len   = LEN_T;
                            end
                        end
                        P_ACC_LIVE: begin
                            if (w_res.hit) begin
                                n_st = cat_pkg::ST_DUP_CALL;
                            end else if (w_res.free) begin
                                w_live_set = 1'b1;
                                n_st = cat_pkg::ST_UPDATED;
                            end else begin
                                n_st = cat_pkg::ST_TFULL;
                            end
                        end
                        P_REJ_OPEN: begin
                            if (w_res.hit) begin
                                w_open_clr = 1'b1;
                                n_st    = cat_pkg::ST_UPDATED;
                                n_drain = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                                n_start = 1'b1;
                                n_step  = P_REJ_DROP;
                                n_len   = LEN_D;
                            end
                        end
                        P_REJ_DROP: begin
                            if (w_res.hit) begin
                                w_drop_clr = 1'b1;
                                n_st = cat_pkg::ST_UPDATED;
                            end
                        end
                        P_DD_DROP: begin
                            if (w_res.hit) begin
                                w_drop_clr = 1'b1;
                                n_state = S_DCALL;
                            end
                        end
                        default: begin
                            if (w_res.hit) begin
                                w_live_clr = 1'b1;
                                n_st    = cat_pkg::ST_UPDATED;
                                n_drain = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DCALL: begin
                // The stored call id of the drop entry replaces the input one.
                n_oc    = r_dc;
                n_key   = r_dc;
                n_step  = P_DD_LIVE;
                n_len   = LEN_T;
                n_start = 1'b1;
                n_state = S_SCAN;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = w_more ? S_POP : S_IDLE;
                end
            end
            S_POP: begin
                w_pop   = 1'b1;
                n_oq    = r_rd;
                n_oc    = '0;
                n_key   = r_rd;
                n_step  = P_ISSUE;
                n_len   = LEN_T;
                n_start = 1'b1;
                n_state = S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, counters and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= 1'b0;
            r_drain    <= 1'b0;
            r_max      <= 5'd4;
            r_head     <= '0;
            r_qcnt     <= '0;
            r_open_cnt <= '0;
            r_live_cnt <= '0;
            r_open_v   <= '0;
            r_live_v   <= '0;
            r_drop_v   <= '0;
            r_m_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_drain <= n_drain;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_max <= pwdata[4:0];
            end
            if (w_push) begin
                r_qcnt <= r_qcnt + 1'b1;
            end
            if (w_pop) begin
                r_qcnt <= r_qcnt - 1'b1;
                r_head <= (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (w_open_set) begin
                r_open_v[w_res.free_idx[TW-1:0]] <= 1'b1;
                r_open_cnt <= r_open_cnt + 1'b1;
            end
            if (w_open_clr) begin
                r_open_v[w_res.hit_idx[TW-1:0]] <= 1'b0;
                r_open_cnt <= r_open_cnt - 1'b1;
            end
            if (w_live_set) begin
                r_live_v[w_res.free_idx[TW-1:0]] <= 1'b1;
                r_live_cnt <= r_live_cnt + 1'b1;
            end
            if (w_live_clr) begin
                r_live_v[w_res.hit_idx[TW-1:0]] <= 1'b0;
                r_live_cnt <= r_live_cnt - 1'b1;
            end
            if (w_drop_set) begin
                r_drop_v[w_res.free_idx[DW-1:0]] <= 1'b1;
            end
            if (w_drop_clr) begin
                r_drop_v[w_res.hit_idx[DW-1:0]] <= 1'b0;
            end
            r_m_vld <= w_load || (r_m_vld && !m_axis_tready);
        end
    end

    // Payload registers and table contents
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_key  <= n_key;
        r_len  <= n_len;
        r_st   <= n_st;
        r_oq   <= n_oq;
        r_oc   <= n_oc;
        if (w_open_set) begin
            r_open_id[w_res.free_idx[TW-1:0]] <= r_key;
        end
        if (w_live_set) begin
            r_live_id[w_res.free_idx[TW-1:0]] <= r_key;
        end
        if (w_drop_set) begin
            r_drop_id[w_res.free_idx[DW-1:0]] <= r_oq;
            r_dcall[w_res.free_idx[DW-1:0]]   <= r_oc;
        end
        r_dc <= r_dcall[w_res.hit_idx[DW-1:0]];
        if (w_push) begin
            r_fifo[w_tail] <= s_axis_tdata[31:0];
        end
        r_rd <= r_fifo[r_head];
        if (w_load) begin
            r_m_st   <= r_st;
            r_m_rq   <= r_oq;
            r_m_cl   <= r_oc;
            r_m_last <= !w_more;
        end
    end

    // Registered table read feeding the shared comparator.
    always_ff @(posedge i_clk) begin
        case (w_sel)
            T_OPEN: begin
                r_ent_id <= r_open_id[w_idx[TW-1:0]];
                r_ent_v  <= r_open_v[w_idx[TW-1:0]];
            end
            T_DROP: begin
                r_ent_id <= r_drop_id[w_idx[DW-1:0]];
                r_ent_v  <= r_drop_v[w_idx[DW-1:0]];
            end
            default: begin
                r_ent_id <= r_live_id[w_idx[TW-1:0]];
                r_ent_v  <= r_live_v[w_idx[TW-1:0]];
            end
        endcase
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = {r_m_cl, r_m_rq};
    assign m_axis_tuser  = r_m_st;
    assign m_axis_tlast  = r_m_last;
    assign prdata = {27'd0, r_max};
    assign pready = 1'b1;

endmodule

FILE: sv/cat_checker.sv
`timescale 1ns / 1ps

module cat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic [31:0] prdata
);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Each input beat is worked on alone: no second beat right after one.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= 4'd9)
        else $error("bad status code");

    // The limit register reads back at most five bits.
    a_prdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[31:5] == 27'd0)
        else $error("limit register wider than five bits");

endmodule

bind call_admission_tracker_unit cat_checker u_cat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .prdata        (prdata)
);
